FILE: design/pts_pkg.sv
// pts_pkg: shared types and codes for the priority task scheduler
// used by pts_ctrl, pts_datapath and priority_task_scheduler
`timescale 1ns / 1ps

package pts_pkg;

    localparam logic [2:0] OP_CREATE  = 3'd0;
    localparam logic [2:0] OP_TICK    = 3'd1;
    localparam logic [2:0] OP_DELAY   = 3'd2;
    localparam logic [2:0] OP_BLOCK   = 3'd3;
    localparam logic [2:0] OP_WAKE    = 3'd4;
    localparam logic [2:0] OP_RAISE   = 3'd5;
    localparam logic [2:0] OP_RESTORE = 3'd6;
    localparam logic [2:0] OP_YIELD   = 3'd7;

    localparam logic [1:0] TS_READY   = 2'd0;
    localparam logic [1:0] TS_RUNNING = 2'd1;
    localparam logic [1:0] TS_BLOCKED = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    localparam logic [31:0] DUR_FOREVER = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SWEEP,
        S_SCAN_INIT,
        S_SCAN,
        S_COMMIT,
        S_RESP
    } t_state;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_EXEC,
        CMD_SWEEP,
        CMD_SCAN_INIT,
        CMD_SCAN,
        CMD_COMMIT
    } t_dp_cmd;

    typedef struct packed {
        logic exec_sweep;
        logic exec_sched;
        logic sweep_last;
        logic scan_last;
        logic empty;
    } t_dp_status;

endpackage

FILE: design/pts_ctrl.sv
// pts_ctrl: command sequencer for the priority task scheduler
// depends on pts_pkg
`timescale 1ns / 1ps

module pts_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  pts_pkg::t_dp_status i_status,
    output pts_pkg::t_dp_cmd    o_cmd,
    output logic                o_busy,
    output logic                o_done
);

    pts_pkg::t_state r_state;
    pts_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pts_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = pts_pkg::CMD_NONE;
        o_busy  = 1'b1;
        o_done  = 1'b0;
        case (r_state)
            pts_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd   = pts_pkg::CMD_LATCH;
                    n_state = pts_pkg::S_EXEC;
                end
            end
            pts_pkg::S_EXEC: begin
                o_cmd = pts_pkg::CMD_EXEC;
                if (i_status.exec_sweep) begin
                    n_state = pts_pkg::S_SWEEP;
                end else if (i_status.exec_sched) begin
                    n_state = pts_pkg::S_SCAN_INIT;
                end else begin
                    n_state = pts_pkg::S_RESP;
                end
            end
            pts_pkg::S_SWEEP: begin
                o_cmd = pts_pkg::CMD_SWEEP;
                if (i_status.sweep_last) begin
                    n_state = pts_pkg::S_SCAN_INIT;
                end
            end
            pts_pkg::S_SCAN_INIT: begin
                o_cmd   = pts_pkg::CMD_SCAN_INIT;
                n_state = i_status.empty ? pts_pkg::S_RESP : pts_pkg::S_SCAN;
            end
            pts_pkg::S_SCAN: begin
                o_cmd = pts_pkg::CMD_SCAN;
                if (i_status.scan_last) begin
                    n_state = pts_pkg::S_COMMIT;
                end
            end
            pts_pkg::S_COMMIT: begin
                o_cmd   = pts_pkg::CMD_COMMIT;
                n_state = pts_pkg::S_RESP;
            end
            pts_pkg::S_RESP: begin
                o_done  = 1'b1;
                n_state = pts_pkg::S_IDLE;
            end
            default: begin
                n_state = pts_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/pts_datapath.sv
// pts_datapath: task table, tick counter, sleep sweep and priority scan
// depends on pts_pkg; sequenced by pts_ctrl
`timescale 1ns / 1ps

module pts_datapath #(
    parameter int TASK_SLOTS = 8,
    parameter int PRIO_BITS  = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pts_pkg::t_dp_cmd    i_cmd,
    input  logic                i_sched_en,
    input  logic [2:0]          i_opcode,
    input  logic [2:0]          i_task_index,
    input  logic [7:0]          i_priority_req,
    input  logic [31:0]         i_duration,
    output pts_pkg::t_dp_status o_status,
    output logic [1:0]          o_result_status,
    output logic [2:0]          o_running_task,
    output logic                o_running_valid,
    output logic                o_switched,
    output logic [7:0]          o_timed_out_mask,
    output logic [31:0]         o_tick_count
);

    localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int TW    = $clog2(TASK_SLOTS + 1);

    logic [PRIO_BITS-1:0] r_base [TASK_SLOTS];
    logic [PRIO_BITS-1:0] r_act  [TASK_SLOTS];
    logic [1:0]           r_tst  [TASK_SLOTS];
    logic [31:0]          r_sleep[TASK_SLOTS];
    logic                 r_wait [TASK_SLOTS];

    logic [TW-1:0]        r_total;
    logic [IDX_W-1:0]     r_cur;
    logic                 r_cval;
    logic [31:0]          r_tick;

    logic [2:0]           r_op;
    logic                 r_tok;
    logic [PRIO_BITS-1:0] r_prio;
    logic [31:0]          r_dur;
    logic [IDX_W-1:0]     r_prev_idx;
    logic                 r_prev_val;
    logic [IDX_W-1:0]     r_ptr;
    logic [IDX_W-1:0]     r_cnt;
    logic [IDX_W-1:0]     r_best;
    logic [PRIO_BITS-1:0] r_bestp;
    logic                 r_found;
    logic [1:0]           r_status;
    logic [7:0]           r_mask;

    logic [IDX_W+2:0]     tgt_w;
    logic [PRIO_BITS+7:0] prio_w;
    logic [IDX_W+2:0]     ptr_w;
    logic [IDX_W+2:0]     cur_w;
    logic [TW-1:0]        total_m1;
    logic                 full;
    logic                 ptr_last;
    logic                 cnt_last;
    logic [IDX_W-1:0]     ptr_next;
    logic [IDX_W-1:0]     scan_start;
    logic                 delay_ok;
    logic                 block_ok;
    logic                 wake_ok;
    logic                 elig;
    logic [31:0]          sleep_dec;

    assign tgt_w      = (IDX_W+3)'(i_task_index);
    assign prio_w     = (PRIO_BITS+8)'(i_priority_req);
    assign ptr_w      = (IDX_W+3)'(r_ptr);
    assign cur_w      = (IDX_W+3)'(r_cur);
    assign total_m1   = r_total - TW'(1);
    assign full       = (r_total >= TW'(TASK_SLOTS));
    assign ptr_last   = (TW'(r_ptr) == total_m1);
    assign cnt_last   = (TW'(r_cnt) == total_m1);
    assign ptr_next   = ptr_last ? '0 : r_ptr + IDX_W'(1);
    assign scan_start = (!r_cval || (TW'(r_cur) + TW'(1) == r_total)) ? '0
                      : r_cur + IDX_W'(1);
    assign delay_ok   = i_sched_en && (r_dur != 32'd0) && r_cval;
    assign block_ok   = r_cval && i_sched_en && (r_dur != 32'd0);
    assign wake_ok    = r_tok && r_wait[r_ptr];
    assign elig       = (r_tst[r_ptr] == pts_pkg::TS_READY)
                     || (r_tst[r_ptr] == pts_pkg::TS_RUNNING);
    assign sleep_dec  = r_sleep[r_ptr] - 32'd1;

    always_comb begin
        o_status            = '0;
        o_status.exec_sweep = (r_op == pts_pkg::OP_TICK) && (r_total != '0);
        case (r_op)
            pts_pkg::OP_TICK:  o_status.exec_sched = 1'b1;
            pts_pkg::OP_DELAY: o_status.exec_sched = delay_ok;
            pts_pkg::OP_BLOCK: o_status.exec_sched = block_ok;
            pts_pkg::OP_WAKE:  o_status.exec_sched = wake_ok;
            pts_pkg::OP_YIELD: o_status.exec_sched = 1'b1;
            default:           o_status.exec_sched = 1'b0;
        endcase
        o_status.sweep_last = ptr_last;
        o_status.scan_last  = cnt_last;
        o_status.empty      = (r_total == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_cur   <= '0;
            r_cval  <= 1'b0;
            r_tick  <= '0;
        end else begin
            case (i_cmd)
                pts_pkg::CMD_EXEC: begin
                    if (r_op == pts_pkg::OP_CREATE && !full) begin
                        if (!r_cval) begin
                            r_cur  <= r_ptr;
                            r_cval <= 1'b1;
                        end
                        r_total <= r_total + TW'(1);
                    end
                    if (r_op == pts_pkg::OP_TICK) begin
                        r_tick <= r_tick + 32'd1;
                    end
                end
                pts_pkg::CMD_COMMIT: begin
                    if (r_found) begin
                        r_cur  <= r_best;
                        r_cval <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            pts_pkg::CMD_LATCH: begin
                r_op       <= i_opcode;
                r_tok      <= ((TW+3)'(i_task_index) < (TW+3)'(r_total));
                r_prio     <= prio_w[PRIO_BITS-1:0];
                r_dur      <= i_duration;
                r_prev_idx <= r_cur;
                r_prev_val <= r_cval;
                r_status   <= pts_pkg::ST_OK;
                r_mask     <= '0;
                case (i_opcode)
                    pts_pkg::OP_CREATE: r_ptr <= r_total[IDX_W-1:0];
                    pts_pkg::OP_DELAY:  r_ptr <= r_cur;
                    pts_pkg::OP_BLOCK:  r_ptr <= r_cur;
                    pts_pkg::OP_WAKE:   r_ptr <= tgt_w[IDX_W-1:0];
                    pts_pkg::OP_RAISE:  r_ptr <= tgt_w[IDX_W-1:0];
                    pts_pkg::OP_RESTORE: r_ptr <= tgt_w[IDX_W-1:0];
                    default:            r_ptr <= '0;
                endcase
            end
            pts_pkg::CMD_EXEC: begin
                case (r_op)
                    pts_pkg::OP_CREATE: begin
                        if (full) begin
                            r_status <= pts_pkg::ST_REFUSED;
                        end else begin
                            r_base[r_ptr]  <= r_prio;
                            r_act[r_ptr]   <= r_prio;
                            r_tst[r_ptr]   <= pts_pkg::TS_READY;
                            r_sleep[r_ptr] <= '0;
                            r_wait[r_ptr]  <= 1'b0;
                        end
                    end
                    pts_pkg::OP_DELAY: begin
                        if (!delay_ok) begin
                            r_status <= pts_pkg::ST_REFUSED;
                        end else begin
                            r_sleep[r_ptr] <= r_dur;
                            r_wait[r_ptr]  <= 1'b0;
                            r_tst[r_ptr]   <= pts_pkg::TS_BLOCKED;
                        end
                    end
                    pts_pkg::OP_BLOCK: begin
                        if (!r_cval) begin
                            r_status <= pts_pkg::ST_REFUSED;
                        end else if (!block_ok) begin
                            r_status <= pts_pkg::ST_TIMEOUT;
                        end else begin
                            r_sleep[r_ptr] <= (r_dur == pts_pkg::DUR_FOREVER) ? '0 : r_dur;
                            r_wait[r_ptr]  <= 1'b1;
                            r_tst[r_ptr]   <= pts_pkg::TS_BLOCKED;
                        end
                    end
                    pts_pkg::OP_WAKE: begin
                        if (!r_tok) begin
                            r_status <= pts_pkg::ST_REFUSED;
                        end else if (!r_wait[r_ptr]) begin
                            r_status <= pts_pkg::ST_REFUSED;
                        end else begin
                            r_sleep[r_ptr] <= '0;
                            r_wait[r_ptr]  <= 1'b0;
                            r_tst[r_ptr]   <= pts_pkg::TS_READY;
                        end
                    end
                    pts_pkg::OP_RAISE: begin
                        if (!r_tok) begin
                            r_status <= pts_pkg::ST_REFUSED;
                        end else if (r_prio > r_act[r_ptr]) begin
                            r_act[r_ptr] <= r_prio;
                        end
                    end
                    pts_pkg::OP_RESTORE: begin
                        if (!r_tok) begin
                            r_status <= pts_pkg::ST_REFUSED;
                        end else begin
                            r_act[r_ptr] <= r_base[r_ptr];
                        end
                    end
                    default: begin
                    end
                endcase
            end
            pts_pkg::CMD_SWEEP: begin
                if (r_sleep[r_ptr] != 32'd0) begin
                    r_sleep[r_ptr] <= sleep_dec;
                    if (sleep_dec == 32'd0) begin
                        if (r_wait[r_ptr]) begin
                            if (ptr_w < (IDX_W+3)'(8)) begin
                                r_mask[ptr_w[2:0]] <= 1'b1;
                            end
                            r_wait[r_ptr] <= 1'b0;
                        end
                        r_tst[r_ptr] <= pts_pkg::TS_READY;
                    end
                end
                r_ptr <= ptr_next;
            end
            pts_pkg::CMD_SCAN_INIT: begin
                r_ptr   <= scan_start;
                r_cnt   <= '0;
                r_found <= 1'b0;
            end
            pts_pkg::CMD_SCAN: begin
                if (elig && (!r_found || r_act[r_ptr] > r_bestp)) begin
                    r_best  <= r_ptr;
                    r_bestp <= r_act[r_ptr];
                    r_found <= 1'b1;
                end
                r_ptr <= ptr_next;
                r_cnt <= r_cnt + IDX_W'(1);
            end
            pts_pkg::CMD_COMMIT: begin
                if (r_found) begin
                    if (r_cval && r_cur != r_best && r_tst[r_cur] == pts_pkg::TS_RUNNING) begin
                        r_tst[r_cur] <= pts_pkg::TS_READY;
                    end
                    r_tst[r_best] <= pts_pkg::TS_RUNNING;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_result_status  = r_status;
    assign o_running_task   = cur_w[2:0];
    assign o_running_valid  = r_cval;
    assign o_switched       = (r_prev_val != r_cval) || (r_cval && r_prev_idx != r_cur);
    assign o_timed_out_mask = r_mask;
    assign o_tick_count     = r_tick;

`ifndef SYNTH
    a_cur_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cval |-> (TW'(r_cur) < r_total))
        else $error("current task beyond task count");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TW'(TASK_SLOTS))
        else $error("task count above slot count");

    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == pts_pkg::CMD_COMMIT && r_found) |=> (r_cval && r_cur == $past(r_best)))
        else $error("commit did not install chosen task");

    a_valid_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_cval) |-> r_cval)
        else $error("current task validity dropped");
`endif

endmodule

FILE: design/priority_task_scheduler.sv
// priority_task_scheduler: top level, APB register and scheduler instances
// depends on pts_pkg, pts_ctrl and pts_datapath
`timescale 1ns / 1ps

// A command is taken when i_start is high and o_busy low; its one result
// appears for a single cycle with o_done and cannot be held off. Create,
// raise, restore and delay/block/wake that do not reschedule go from
// execution to the result; yield and rescheduling delay/block/wake
// first scan the created tasks by priority, and a tick first sweeps the
// sleep counts, then scans (tick skips both, yield the scan, while no task
// exists); sweep and scan each visit one task slot per cycle through one
// table port. o_busy is still high in the result cycle, so the next
// command is taken in the cycle after the result at the earliest.
// The scheduler enable register (bit 0) reads at APB address 0, any APB
// write loads it; delay is refused and block times out while it is clear.

module priority_task_scheduler #(
    parameter int TASK_SLOTS = 8,
    parameter int PRIO_BITS  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_opcode,
    input  logic [2:0]  i_task_index,
    input  logic [7:0]  i_priority_req,
    input  logic [31:0] i_duration,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [2:0]  o_running_task,
    output logic        o_running_valid,
    output logic        o_switched,
    output logic [7:0]  o_timed_out_mask,
    output logic [31:0] o_tick_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                r_sched_en;
    pts_pkg::t_dp_cmd    cmd;
    pts_pkg::t_dp_status dp_status;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {31'd0, r_sched_en} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sched_en <= 1'b0;
        end else if (psel && penable && pwrite) begin
            r_sched_en <= pwdata[0];
        end
    end

    pts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (dp_status),
        .o_cmd    (cmd),
        .o_busy   (o_busy),
        .o_done   (o_done)
    );

    pts_datapath #(
        .TASK_SLOTS (TASK_SLOTS),
        .PRIO_BITS  (PRIO_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_sched_en       (r_sched_en),
        .i_opcode         (i_opcode),
        .i_task_index     (i_task_index),
        .i_priority_req   (i_priority_req),
        .i_duration       (i_duration),
        .o_status         (dp_status),
        .o_result_status  (o_status),
        .o_running_task   (o_running_task),
        .o_running_valid  (o_running_valid),
        .o_switched       (o_switched),
        .o_timed_out_mask (o_timed_out_mask),
        .o_tick_count     (o_tick_count)
    );

endmodule

FILE: dv/tb_priority_task_scheduler.sv
// tb_priority_task_scheduler: self-checking testbench for the priority task scheduler
// predicts every command result in step with acceptance, checks each o_done transaction
// depends on pts_pkg and priority_task_scheduler
`timescale 1ns / 1ps

module tb_priority_task_scheduler;

    localparam int SLOTS = 8;
    localparam int STALL_LIMIT = 5000;

    typedef struct {
        logic [2:0]  op;
        logic [2:0]  idx;
        logic [7:0]  prio;
        logic [31:0] dur;
    } t_cmd;

    typedef struct {
        logic [1:0]  status;
        logic [2:0]  run_task;
        logic        run_valid;
        logic        switched;
        logic [7:0]  mask;
        logic [31:0] ticks;
    } t_outcome;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_start = 0;
    logic        o_busy;
    logic [2:0]  i_opcode = '0;
    logic [2:0]  i_task_index = '0;
    logic [7:0]  i_priority_req = '0;
    logic [31:0] i_duration = '0;
    logic        o_done;
    logic [1:0]  o_status;
    logic [2:0]  o_running_task;
    logic        o_running_valid;
    logic        o_switched;
    logic [7:0]  o_timed_out_mask;
    logic [31:0] o_tick_count;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    priority_task_scheduler u_dut (.*);

    always #1 i_clk = ~i_clk;

    // scheduler copy kept by the testbench
    logic        kernel_on;
    int          n_tasks;
    logic [2:0]  cur_task;
    logic        cur_valid;
    logic [31:0] tick_total;
    logic [7:0]  base_p   [SLOTS];
    logic [7:0]  active_p [SLOTS];
    logic [1:0]  t_state_q[SLOTS];
    logic [31:0] sleep_q  [SLOTS];
    logic        waiting_q[SLOTS];

    t_cmd     pending_cmds[$];
    t_outcome expected_outcomes[$];
    int       error_count = 0;
    int       sender_idle_pct = 0;
    int       quiet_cycles = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic reschedule();
        int first;
        int slot;
        int best;
        bit found;
        found = 0;
        best = 0;
        if (n_tasks == 0) return;
        first = cur_valid ? int'(cur_task) + 1 : 0;
        for (int k = 0; k < n_tasks; k++) begin
            slot = (first + k) % n_tasks;
            if (t_state_q[slot] != pts_pkg::TS_READY &&
                t_state_q[slot] != pts_pkg::TS_RUNNING) continue;
            if (!found || active_p[slot] > active_p[best]) begin
                best = slot;
                found = 1;
            end
        end
        if (!found) return;
        if (cur_valid && int'(cur_task) != best &&
            t_state_q[cur_task] == pts_pkg::TS_RUNNING)
            t_state_q[cur_task] = pts_pkg::TS_READY;
        t_state_q[best] = pts_pkg::TS_RUNNING;
        cur_task = best[2:0];
        cur_valid = 1;
    endtask

    task automatic predict_schedule(input t_cmd c, output t_outcome r);
        logic [2:0] prev_task;
        logic       prev_valid;
        bit         idx_ok;
        prev_task = cur_task;
        prev_valid = cur_valid;
        idx_ok = int'(c.idx) < n_tasks;
        r.status = pts_pkg::ST_OK;
        r.mask = '0;
        case (c.op)
            pts_pkg::OP_CREATE: begin
                if (n_tasks >= SLOTS) r.status = pts_pkg::ST_REFUSED;
                else begin
                    base_p[n_tasks] = c.prio;
                    active_p[n_tasks] = c.prio;
                    t_state_q[n_tasks] = pts_pkg::TS_READY;
                    sleep_q[n_tasks] = '0;
                    waiting_q[n_tasks] = 0;
                    if (!cur_valid) begin
                        cur_task = n_tasks[2:0];
                        cur_valid = 1;
                    end
                    n_tasks++;
                end
            end
            pts_pkg::OP_TICK: begin
                tick_total++;
                for (int i = 0; i < n_tasks; i++) begin
                    if (sleep_q[i] == 0) continue;
                    sleep_q[i]--;
                    if (sleep_q[i] == 0) begin
                        if (waiting_q[i]) begin
                            r.mask[i] = 1'b1;
                            waiting_q[i] = 0;
                        end
                        t_state_q[i] = pts_pkg::TS_READY;
                    end
                end
                reschedule();
            end
            pts_pkg::OP_DELAY: begin
                if (!kernel_on || c.dur == 0 || !cur_valid) r.status = pts_pkg::ST_REFUSED;
                else begin
                    sleep_q[cur_task] = c.dur;
                    waiting_q[cur_task] = 0;
                    t_state_q[cur_task] = pts_pkg::TS_BLOCKED;
                    reschedule();
                end
            end
            pts_pkg::OP_BLOCK: begin
                if (!cur_valid) r.status = pts_pkg::ST_REFUSED;
                else if (!kernel_on || c.dur == 0) r.status = pts_pkg::ST_TIMEOUT;
                else begin
                    sleep_q[cur_task] = (c.dur == pts_pkg::DUR_FOREVER) ? 32'd0 : c.dur;
                    waiting_q[cur_task] = 1;
                    t_state_q[cur_task] = pts_pkg::TS_BLOCKED;
                    reschedule();
                end
            end
            pts_pkg::OP_WAKE: begin
                if (!idx_ok) r.status = pts_pkg::ST_REFUSED;
                else if (!waiting_q[c.idx]) r.status = pts_pkg::ST_REFUSED;
                else begin
                    sleep_q[c.idx] = '0;
                    waiting_q[c.idx] = 0;
                    t_state_q[c.idx] = pts_pkg::TS_READY;
                    reschedule();
                end
            end
            pts_pkg::OP_RAISE: begin
                if (!idx_ok) r.status = pts_pkg::ST_REFUSED;
                else if (c.prio > active_p[c.idx]) active_p[c.idx] = c.prio;
            end
            pts_pkg::OP_RESTORE: begin
                if (!idx_ok) r.status = pts_pkg::ST_REFUSED;
                else active_p[c.idx] = base_p[c.idx];
            end
            default: reschedule();
        endcase
        r.run_task = cur_task;
        r.run_valid = cur_valid;
        r.switched = (prev_valid != cur_valid) || (cur_valid && prev_task != cur_task);
        r.ticks = tick_total;
    endtask

    // driver
    always @(posedge i_clk) begin
        t_cmd     c;
        t_outcome r;
        logic     next_start;
        next_start = i_start;
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                c = pending_cmds.pop_front();
                predict_schedule(c, r);
                expected_outcomes.push_back(r);
                next_start = 0;
            end
            if (!next_start && pending_cmds.size() > 0 &&
                $urandom_range(99) >= sender_idle_pct) begin
                c = pending_cmds[0];
                i_opcode <= c.op;
                i_task_index <= c.idx;
                i_priority_req <= c.prio;
                i_duration <= c.dur;
                next_start = 1;
            end
        end
        i_start <= next_start;
    end

    // monitor
    always @(posedge i_clk) begin
        t_outcome w;
        if (i_rst_n && o_done) begin
            if (expected_outcomes.size() == 0) begin
                report_mismatch("unexpected result", 32'd1, 32'd0);
            end else begin
                w = expected_outcomes.pop_front();
                if (o_status !== w.status)
                    report_mismatch("status", 32'(o_status), 32'(w.status));
                if (o_running_task !== w.run_task)
                    report_mismatch("running_task", 32'(o_running_task), 32'(w.run_task));
                if (o_running_valid !== w.run_valid)
                    report_mismatch("running_valid", 32'(o_running_valid), 32'(w.run_valid));
                if (o_switched !== w.switched)
                    report_mismatch("switched", 32'(o_switched), 32'(w.switched));
                if (o_timed_out_mask !== w.mask)
                    report_mismatch("timed_out_mask", 32'(o_timed_out_mask), 32'(w.mask));
                if (o_tick_count !== w.ticks)
                    report_mismatch("tick_count", o_tick_count, w.ticks);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || psel) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic add_cmd(input logic [2:0] op, input logic [2:0] idx,
                           input logic [7:0] prio, input logic [31:0] dur);
        t_cmd c;
        c.op = op;
        c.idx = idx;
        c.prio = prio;
        c.dur = dur;
        pending_cmds.push_back(c);
    endtask

    task automatic drain();
        while (pending_cmds.size() > 0 || i_start || expected_outcomes.size() > 0)
            @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    task automatic write_kernel(input logic value);
        @(posedge i_clk);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= '0;
        pwdata <= {31'd0, value};
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        kernel_on = value;
    endtask

    function automatic logic [31:0] pick_duration();
        int roll;
        roll = $urandom_range(99);
        if (roll < 68) return $urandom_range(6, 1);
        if (roll < 78) return 32'd0;
        if (roll < 88) return pts_pkg::DUR_FOREVER;
        return $urandom;
    endfunction

    function automatic logic [2:0] pick_opcode();
        int roll;
        roll = $urandom_range(99);
        if (roll < 30) return pts_pkg::OP_TICK;
        if (roll < 42) return pts_pkg::OP_DELAY;
        if (roll < 57) return pts_pkg::OP_BLOCK;
        if (roll < 72) return pts_pkg::OP_WAKE;
        if (roll < 80) return pts_pkg::OP_RAISE;
        if (roll < 86) return pts_pkg::OP_RESTORE;
        if (roll < 96) return pts_pkg::OP_YIELD;
        return pts_pkg::OP_CREATE;
    endfunction

    initial begin
        int idle_plan[6] = '{0, 88, 26, 0, 88, 26};
        kernel_on = 0;
        n_tasks = 0;
        cur_task = '0;
        cur_valid = 0;
        tick_total = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;

        // kernel stopped: commands before any task exists, then two creates and delay/block
        add_cmd(pts_pkg::OP_DELAY, 3'd0, 8'd0, 32'd5);
        add_cmd(pts_pkg::OP_BLOCK, 3'd0, 8'd0, 32'd5);
        add_cmd(pts_pkg::OP_WAKE, 3'd7, 8'd0, 32'd0);
        add_cmd(pts_pkg::OP_RAISE, 3'd0, 8'hFF, 32'd0);
        add_cmd(pts_pkg::OP_RESTORE, 3'd7, 8'd0, 32'd0);
        add_cmd(pts_pkg::OP_YIELD, 3'd0, 8'd0, 32'd0);
        add_cmd(pts_pkg::OP_TICK, 3'd0, 8'd0, 32'd0);
        add_cmd(pts_pkg::OP_CREATE, 3'd0, 8'd0, 32'd0);
        add_cmd(pts_pkg::OP_CREATE, 3'd5, 8'hFF, 32'hFFFF_FFFF);
        add_cmd(pts_pkg::OP_DELAY, 3'd0, 8'd0, 32'd3);
        add_cmd(pts_pkg::OP_BLOCK, 3'd0, 8'd0, 32'd3);
        drain();
        write_kernel(1);

        add_cmd(pts_pkg::OP_CREATE, 3'd0, 8'd7, 32'd0);
        add_cmd(pts_pkg::OP_CREATE, 3'd0, 8'd7, 32'd0);
        add_cmd(pts_pkg::OP_YIELD, 3'd0, 8'd0, 32'd0);
        add_cmd(pts_pkg::OP_DELAY, 3'd0, 8'd0, 32'd0);
        add_cmd(pts_pkg::OP_BLOCK, 3'd0, 8'd0, 32'd0);
        add_cmd(pts_pkg::OP_BLOCK, 3'd0, 8'd0, 32'd2);
        add_cmd(pts_pkg::OP_BLOCK, 3'd0, 8'd0, pts_pkg::DUR_FOREVER);
        add_cmd(pts_pkg::OP_DELAY, 3'd0, 8'd0, 32'd1);
        add_cmd(pts_pkg::OP_TICK, 3'd0, 8'd0, 32'd0);
        add_cmd(pts_pkg::OP_TICK, 3'd0, 8'd0, 32'd0);
        add_cmd(pts_pkg::OP_WAKE, 3'd1, 8'd0, 32'd0);
        add_cmd(pts_pkg::OP_WAKE, 3'd6, 8'd0, 32'd0);
        add_cmd(pts_pkg::OP_RAISE, 3'd2, 8'hFE, 32'd0);
        add_cmd(pts_pkg::OP_RAISE, 3'd2, 8'd1, 32'd0);
        add_cmd(pts_pkg::OP_RESTORE, 3'd2, 8'd0, 32'd0);
        drain();

        for (int p = 0; p < 6; p++) begin
            write_kernel(p != 3);
            sender_idle_pct = idle_plan[p];
            for (int n = 0; n < 200; n++)
                add_cmd(pick_opcode(), 3'($urandom_range(7)), 8'($urandom_range(255)),
                        pick_duration());
            drain();
        end

        if (error_count == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule
